>>> sv/lcf_pkg.sv
// ----------------------------------------------------------------------------
// lcf_pkg: shared types and constants for the linear convolution FIR
// Widths, register indexes, reset values and the control types passed
// between the flush controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lcf_pkg;

  // Structural limits and defaults
  localparam int MAX_TAPS        = 7;
  localparam int DEF_TAPS        = 7;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int TREE_LEAVES     = 8;

  // Field widths
  localparam int COEF_W     = 16;
  localparam int SUM_W      = 35;
  localparam int TAP_CNT_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [COEF_W-1:0]    coef_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic        [TAP_CNT_W-1:0] tap_cnt_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

  // Register map
  localparam cfg_idx_t REG_TAP_COUNT  = 3'd0;
  localparam cfg_idx_t REG_COEF_FIRST = 3'd1;

  // Reset values
  localparam tap_cnt_t TAP_COUNT_RST = 3'd1;
  localparam coef_t    COEF_ONE      = 16'sd16384;

  // Flush controller states
  typedef enum logic {
    ST_STREAM,
    ST_FLUSH
  } flush_state_t;

  // Step command from the flush controller to the tap chain
  typedef struct packed {
    logic fire;     // delay line shifts this cycle
    logic zero;     // shift in a zero instead of the input sample
    logic seq_end;  // last output of the sequence, clear the line after it
    logic busy;     // tail flush in progress
  } step_t;

endpackage

`default_nettype wire

>>> sv/lcf_sample_if.sv
// ----------------------------------------------------------------------------
// lcf_sample_if: input sample channel
// Valid/ready channel carrying one sample and its end-of-sequence mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcf_sample_if import lcf_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          final_sample;

  modport source (output valid, sample, final_sample, input ready);
  modport sink   (input valid, sample, final_sample, output ready);

endinterface

`default_nettype wire

>>> sv/lcf_result_if.sv
// ----------------------------------------------------------------------------
// lcf_result_if: output result channel
// Valid/ready channel carrying one convolution output and its end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcf_result_if import lcf_pkg::*; ();

  logic valid;
  logic ready;
  sum_t sum_value;
  logic sequence_end;

  modport source (output valid, sum_value, sequence_end, input ready);
  modport sink   (input valid, sum_value, sequence_end, output ready);

endinterface

`default_nettype wire

>>> sv/lcf_tap_cell.sv
// ----------------------------------------------------------------------------
// lcf_tap_cell: one tap of the delay line
// Holds one delayed sample, passes it to the next cell on each step and
// registers the product of the incoming tap value and its coefficient.
// ----------------------------------------------------------------------------
`default_nettype none

module lcf_tap_cell import lcf_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 shift,
  input  wire logic                                 clear,
  input  wire logic                                 active,
  input  wire logic signed [SAMPLE_BITS-1:0]        tap_in,
  input  wire coef_t                                coef,
  output      logic signed [SAMPLE_BITS-1:0]        tap_out,
  output      logic signed [SAMPLE_BITS+COEF_W-1:0] product
);

  localparam int PROD_W = SAMPLE_BITS + COEF_W;

  coef_t coef_eff;

  // Inactive taps contribute nothing
  assign coef_eff = active ? coef : '0;

  // Delay register: advance on a step, drop the history at sequence end
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_out <= '0;
    end else if (shift) begin
      tap_out <= clear ? '0 : tap_in;
    end
  end

  // Product of this tap's value in the window of the current step
  always_ff @(posedge clk) begin
    if (shift) begin
      product <= PROD_W'(tap_in) * PROD_W'(coef_eff);
    end
  end

endmodule

`default_nettype wire

>>> sv/lcf_sum_tree.sv
// ----------------------------------------------------------------------------
// lcf_sum_tree: registered adder tree with output register
// Sums eight tap products over three registered levels; the last level is
// the output register of the block. Each level advances when it is empty or
// the level after it advances.
// ----------------------------------------------------------------------------
`default_nettype none

module lcf_sum_tree import lcf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic leaf_valid,
  input  wire logic leaf_end,
  input  wire sum_t leaves [TREE_LEAVES],
  output      logic leaf_take,
  output      logic out_valid,
  output      logic out_end,
  output      sum_t out_sum,
  input  wire logic out_ready
);

  sum_t lvl2 [TREE_LEAVES/2];
  sum_t lvl3 [TREE_LEAVES/4];
  logic v2, v3;
  logic e2, e3;
  logic en2, en3, en4;

  // Stage enables, from the output backward
  assign en4       = !out_valid || out_ready;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign leaf_take = en2;

  // First level: pairwise sums of the leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= leaf_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      e2 <= leaf_end;
      for (int i = 0; i < TREE_LEAVES/2; i++) begin
        lvl2[i] <= leaves[2*i] + leaves[2*i+1];
      end
    end
  end

  // Second level
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      e3 <= e2;
      for (int i = 0; i < TREE_LEAVES/4; i++) begin
        lvl3[i] <= lvl2[2*i] + lvl2[2*i+1];
      end
    end
  end

  // Output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_end <= e3;
      out_sum <= lvl3[0] + lvl3[1];
    end
  end

endmodule

`default_nettype wire

>>> sv/lcf_flush_ctrl.sv
// ----------------------------------------------------------------------------
// lcf_flush_ctrl: step sequencer for streaming and tail flush
// Turns accepted samples into steps of the tap chain and, after a final
// sample, issues the zero-input tail steps of the convolution.
// ----------------------------------------------------------------------------
`default_nettype none

module lcf_flush_ctrl import lcf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_final,
  input  wire logic     advance,
  input  wire tap_cnt_t taps,
  output      logic     in_ready,
  output      step_t    step
);

  flush_state_t state, state_next;
  tap_cnt_t     remain, remain_next;

  // State and tail counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_STREAM;
      remain <= '0;
    end else begin
      state  <= state_next;
      remain <= remain_next;
    end
  end

  // Next state
  always_comb begin
    state_next  = state;
    remain_next = remain;
    unique case (state)
      ST_STREAM: begin
        if (advance && in_valid && in_final && taps != tap_cnt_t'(1)) begin
          state_next  = ST_FLUSH;
          remain_next = taps - tap_cnt_t'(1);
        end
      end
      ST_FLUSH: begin
        if (advance) begin
          remain_next = remain - tap_cnt_t'(1);
          if (remain == tap_cnt_t'(1)) begin
            state_next = ST_STREAM;
          end
        end
      end
      default: begin
        state_next = ST_STREAM;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = 1'b0;
    step.fire    = 1'b0;
    step.zero    = 1'b0;
    step.seq_end = 1'b0;
    step.busy    = 1'b0;
    unique case (state)
      ST_STREAM: begin
        in_ready     = advance;
        step.fire    = advance && in_valid;
        step.seq_end = in_final && taps == tap_cnt_t'(1);
      end
      ST_FLUSH: begin
        step.fire    = advance;
        step.zero    = 1'b1;
        step.seq_end = remain == tap_cnt_t'(1);
        step.busy    = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/linear_convolution_fir.sv
// Path: tap product register, two adder levels, output register. Throughput:
// one sample per cycle while the result channel accepts; a final sample is
// followed by taps-1 tail outputs at that rate, with the sample channel held
// off. Each output costs one step of the tap chain; the adder tree keeps pace.
// Reset: synchronous; tap_count = 1, coef_0 = 1.0, other coefficients and the
// delay line cleared, pipeline empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
// linear_convolution_fir: direct-form FIR computing full linear convolution
// A chain of tap cells holds the delay line and forms the tap products; a
// registered adder tree sums them. A flush sequencer adds the tail outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_convolution_fir import lcf_pkg::*; #(
  parameter int TAPS        = DEF_TAPS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire cfg_idx_t              cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  lcf_sample_if.sink                 samples,
  lcf_result_if.source               results
);

  localparam int       PROD_W = SAMPLE_BITS + COEF_W;
  localparam tap_cnt_t TAPS_C = tap_cnt_t'(TAPS);

  tap_cnt_t tap_count;
  tap_cnt_t taps;
  coef_t    coef [MAX_TAPS];
  cfg_idx_t coef_sel;

  step_t step;
  logic  v1, e1;
  logic  en1, tree_take;
  logic  line_clear;

  logic signed [SAMPLE_BITS-1:0] tap_in  [TAPS];
  logic signed [SAMPLE_BITS-1:0] tap_q   [TAPS];
  logic signed [PROD_W-1:0]      product [TAPS];
  sum_t                          leaves  [TREE_LEAVES];

  // Configuration registers
  assign coef_sel = cfg_index - REG_COEF_FIRST;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RST;
      for (int i = 0; i < MAX_TAPS; i++) begin
        coef[i] <= (i == 0) ? COEF_ONE : '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_TAP_COUNT) begin
        tap_count <= cfg_data[TAP_CNT_W-1:0];
      end else begin
        coef[coef_sel] <= coef_t'(cfg_data);
      end
    end
  end

  // Active tap count: zero acts as one, saturate at the built length
  always_comb begin
    priority if (tap_count == '0) begin
      taps = tap_cnt_t'(1);
    end else if (tap_count > TAPS_C) begin
      taps = TAPS_C;
    end else begin
      taps = tap_count;
    end
  end

  // Step sequencer
  lcf_flush_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_final (samples.final_sample),
    .advance  (en1),
    .taps     (taps),
    .in_ready (samples.ready),
    .step     (step)
  );

  // Tap chain: each cell takes its neighbor's delayed sample
  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    if (k == 0) begin : g_head
      assign tap_in[k] = step.zero ? '0 : samples.sample;
    end else begin : g_body
      assign tap_in[k] = tap_q[k-1];
    end

    lcf_tap_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (step.fire),
      .clear   (step.seq_end),
      .active  (tap_cnt_t'(k) < taps),
      .tap_in  (tap_in[k]),
      .coef    (coef[k]),
      .tap_out (tap_q[k]),
      .product (product[k])
    );
  end

  // Product stage valid and end flag
  assign en1 = !v1 || tree_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= step.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      e1 <= step.seq_end;
    end
  end

  // Tree leaves: products at sum width, unused leaves zero
  for (genvar k = 0; k < TREE_LEAVES; k++) begin : g_leaf
    if (k < TAPS) begin : g_used
      assign leaves[k] = SUM_W'(product[k]);
    end else begin : g_pad
      assign leaves[k] = '0;
    end
  end

  lcf_sum_tree u_tree (
    .clk        (clk),
    .rst        (rst),
    .leaf_valid (v1),
    .leaf_end   (e1),
    .leaves     (leaves),
    .leaf_take  (tree_take),
    .out_valid  (results.valid),
    .out_end    (results.sequence_end),
    .out_sum    (results.sum_value),
    .out_ready  (results.ready)
  );

  // Delay line empty check
  always_comb begin
    line_clear = 1'b1;
    for (int i = 0; i < TAPS; i++) begin
      if (tap_q[i] != '0) begin
        line_clear = 1'b0;
      end
    end
  end

  // Assertions
  a_end_clears_line: assert property (@(posedge clk) disable iff (rst)
    step.fire && step.seq_end |=> line_clear)
    else $error("delay line not cleared after sequence end");

  a_end_leaves_flush: assert property (@(posedge clk) disable iff (rst)
    step.fire && step.seq_end |=> !step.busy)
    else $error("tail flush continues past sequence end");

  a_no_input_in_flush: assert property (@(posedge clk) disable iff (rst)
    step.busy |-> !step.fire || step.zero)
    else $error("sample step issued during tail flush");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !results.valid && !v1)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
